[rtl/core/fsc_pkg.sv]
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, constants and helper functions of the frustum sphere culler.
// ----------------------------------------------------------------------------
package fsc_pkg;

    localparam int CoordW    = 32;   // Q16.16 coordinates, offsets and distances
    localparam int NormFrac  = 30;   // normals are Q2.30
    localparam int AccW      = 66;   // exact sum of three 32x32 products
    localparam int DotW      = AccW - NormFrac;
    localparam int EdgeW     = CoordW + 1;
    localparam int CrossW    = 2 * CoordW - 1;  // cross product magnitude
    localparam int RootW     = 31;   // square root and quotient width
    localparam int RadW      = 2 * RootW;
    localparam int DvdW      = RadW - 1;
    localparam int RemW      = RootW + 3;
    localparam int NumPlanes = 6;
    localparam int NumCorner = 8;
    localparam int NumAxes   = 3;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_TEST  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_EDGE,
        S_FIT,
        S_CROSS,
        S_NORM,
        S_SUMSQ,
        S_SQRT,
        S_DIV,
        S_OFFS,
        S_WRITE,
        S_TEST,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic       valid;
        logic       clr;
        logic       neg;
        logic       last;
        logic [2:0] tag;
    } t_mac_req;

    typedef struct packed {
        logic       done;
        logic [2:0] tag;
    } t_mac_rsp;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_rd_cmd;

    // Corner k of the triple that spans plane p.
    function automatic logic [2:0] plane_pt(input logic [2:0] p, input logic [1:0] k);
        logic [8:0] row;
        unique case (p)
            3'd0:    row = {3'd1, 3'd5, 3'd6};
            3'd1:    row = {3'd4, 3'd0, 3'd3};
            3'd2:    row = {3'd4, 3'd5, 3'd1};
            3'd3:    row = {3'd3, 3'd2, 3'd6};
            3'd4:    row = {3'd5, 3'd4, 3'd7};
            3'd5:    row = {3'd0, 3'd1, 3'd2};
            default: row = '0;
        endcase
        unique case (k)
            2'd0:    return row[8:6];
            2'd1:    return row[5:3];
            default: return row[2:0];
        endcase
    endfunction

    // Shift a Q2.30 dot product sum right by 30, rounding half up.
    function automatic logic signed [DotW-1:0] round_q30(input logic signed [AccW-1:0] v);
        logic signed [AccW-1:0] s;
        s = v + (AccW'(1) <<< (NormFrac - 1));
        return s[AccW-1:NormFrac];
    endfunction

    function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [DotW:0] v);
        logic signed [DotW:0] hi;
        logic signed [DotW:0] lo;
        hi = (DotW + 1)'((64'sd1 <<< (CoordW - 1)) - 64'sd1);
        lo = -hi - (DotW + 1)'(1);
        if (v > hi) begin
            return {1'b0, {(CoordW - 1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(CoordW - 1){1'b0}}};
        end
        return v[CoordW-1:0];
    endfunction

endpackage

[rtl/core/fsc_mac.sv]
// ----------------------------------------------------------------------------
// fsc_mac
// Shared signed multiplier with a registered product and an accumulator.
// ----------------------------------------------------------------------------
module fsc_mac import fsc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_req                 i_req,
    input  logic signed [CoordW-1:0] i_a,
    input  logic signed [CoordW-1:0] i_b,
    output logic signed [AccW-1:0]   o_acc,
    output t_mac_rsp                 o_rsp
);

    logic signed [2*CoordW-1:0] r_prod;
    t_mac_req                   r_req;
    t_mac_rsp                   r_rsp;
    logic signed [AccW-1:0]     r_acc;
    logic signed [AccW-1:0]     n_acc;
    logic signed [AccW-1:0]     w_term;

    always_comb begin
        w_term = AccW'(r_prod);
        n_acc  = (r_req.clr ? '0 : r_acc) + (r_req.neg ? -w_term : w_term);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req <= '0;
            r_rsp <= '0;
        end else begin
            r_req      <= i_req;
            r_rsp.done <= r_req.valid && r_req.last;
            r_rsp.tag  <= r_req.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_req.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
    assign o_rsp = r_rsp;

endmodule

[rtl/core/fsc_rootdiv.sv]
// ----------------------------------------------------------------------------
// fsc_rootdiv
// Iterative unit for the integer square root and the normal division. Both
// share one compare and subtract and retire one result bit per cycle.
// ----------------------------------------------------------------------------
module fsc_rootdiv import fsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_rd_cmd          i_cmd,
    input  logic [RadW-1:0]  i_radicand,
    input  logic [DvdW-1:0]  i_dividend,
    input  logic [RootW-1:0] i_divisor,
    output logic             o_done,
    output logic [RootW-1:0] o_res
);

    logic             r_busy;
    logic             r_done;
    logic             r_mode;
    logic [4:0]       r_cnt;
    logic [RemW-1:0]  r_rem;
    logic [RootW-1:0] r_res;
    logic [RootW-1:0] r_div;
    logic [RadW-1:0]  r_src;
    logic [RemW-1:0]  w_rem;
    logic [RemW-1:0]  w_trial;
    logic [RemW-1:0]  w_diff;
    logic             w_ge;

    always_comb begin
        if (r_mode) begin
            w_rem   = {r_rem[RemW-2:0], r_src[RadW-1]};
            w_trial = {3'b000, r_div};
        end else begin
            // Square root: bring down two bits, trial is 4*root + 1.
            w_rem   = {r_rem[RemW-3:0], r_src[RadW-1 -: 2]};
            w_trial = {1'b0, r_res, 2'b01};
        end
        w_ge   = (w_rem >= w_trial);
        w_diff = w_rem - w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_mode <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_mode <= i_cmd.is_div;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(RootW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_res <= '0;
            r_div <= i_divisor;
            if (i_cmd.is_div) begin
                // The quotient fits in RootW bits, so the top part is below the divisor.
                r_rem <= RemW'(i_dividend[DvdW-1:RootW]);
                r_src <= {i_dividend[RootW-1:0], {(RadW - RootW){1'b0}}};
            end else begin
                r_rem <= '0;
                r_src <= i_radicand;
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_rem;
            r_res <= {r_res[RootW-2:0], w_ge};
            r_src <= r_mode ? (r_src << 1) : (r_src << 2);
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

[rtl/core/frustum_sphere_culler.sv]
// ----------------------------------------------------------------------------
// frustum_sphere_culler
// View frustum culling of bounding spheres against six stored planes.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_ready) carries an op code with a corner index,
// a Q16.16 point and a radius. A load writes one frustum corner. A build
// forms all six planes from the stored corners; most of the work for each
// plane lies in the one-bit-per-cycle square root and the three divisions of
// the shared root/divide unit, which a plane whose normal has zero length
// skips. A test runs eighteen products through the one shared multiplier.
// o_ready is high only while the sequencer is idle; one item is in work at a
// time. Only a test produces a result on the output channel (o_valid,
// i_ready): o_inside_res is 1 unless the sphere lies wholly outside a plane.
// The result sits in an output register, so a new item may be taken while it
// waits; a finished test holds in place until that register is free.
// Reset clears all planes to zero, so a test before any build reports inside.
// Corners are undefined until loaded.
// ----------------------------------------------------------------------------
module frustum_sphere_culler import fsc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_op,
    input  logic [2:0]               i_corner_index,
    input  logic signed [CoordW-1:0] i_coord_x,
    input  logic signed [CoordW-1:0] i_coord_y,
    input  logic signed [CoordW-1:0] i_coord_z,
    input  logic [CoordW-2:0]        i_radius,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_inside_res
);

    t_state r_state, n_state;
    logic [2:0] r_plane;
    logic [2:0] r_cnt;

    logic [NumAxes*CoordW-1:0] r_mem [NumCorner];
    logic [NumAxes*CoordW-1:0] r_rd;
    logic [2:0]                w_rd_addr;

    logic signed [CoordW-1:0] r_p1 [NumAxes];
    logic signed [CoordW-1:0] r_p2 [NumAxes];
    logic signed [CoordW-1:0] r_p3 [NumAxes];
    logic [EdgeW-1:0]         r_u_mag [NumAxes];
    logic [EdgeW-1:0]         r_w_mag [NumAxes];
    logic                     r_u_neg [NumAxes];
    logic                     r_w_neg [NumAxes];
    logic [CrossW-1:0]        r_c_mag [NumAxes];
    logic                     r_c_neg [NumAxes];
    logic [RootW-1:0]         r_len;
    logic signed [CoordW-1:0] r_n [NumAxes];
    logic signed [CoordW-1:0] r_off;
    logic                     r_zero;

    logic signed [CoordW-1:0] r_pn [NumPlanes][NumAxes];
    logic signed [CoordW-1:0] r_pd [NumPlanes];

    logic signed [CoordW-1:0] r_ctr [NumAxes];
    logic [CoordW-2:0]        r_rad;
    logic                     r_outside;
    logic                     r_ovalid;
    logic                     r_ores;

    logic                     w_fire;
    logic                     w_u_big;
    logic                     w_w_big;
    logic                     w_c_big;
    logic                     w_c_small;
    logic                     w_c_zero;
    logic signed [CoordW-1:0] w_u [NumAxes];
    logic signed [CoordW-1:0] w_w [NumAxes];
    logic signed [EdgeW-1:0]  w_du [NumAxes];
    logic signed [EdgeW-1:0]  w_dw [NumAxes];

    t_mac_req                 w_mreq;
    logic signed [CoordW-1:0] w_ma;
    logic signed [CoordW-1:0] w_mb;
    logic signed [AccW-1:0]   w_acc;
    t_mac_rsp                 w_mrsp;
    logic [CrossW-1:0]        w_acc_mag;

    t_rd_cmd                  w_rcmd;
    logic [1:0]               w_div_idx;
    logic [RootW-1:0]         w_divisor;
    logic [DvdW-1:0]          w_dividend;
    logic                     w_rdone;
    logic [RootW-1:0]         w_rres;
    logic signed [CoordW-1:0] w_q;

    logic signed [DotW-1:0]   w_dot;
    logic signed [CoordW-1:0] w_dist;
    logic signed [CoordW-1:0] w_offs;

    assign w_fire = i_valid && o_ready;

    // ---------------- combinational datapath helpers ----------------
    always_comb begin
        for (int i = 0; i < NumAxes; i++) begin
            w_du[i] = {r_p1[i][CoordW-1], r_p1[i]} - {r_p2[i][CoordW-1], r_p2[i]};
            w_dw[i] = {r_p1[i][CoordW-1], r_p1[i]} - {r_p3[i][CoordW-1], r_p3[i]};
            w_u[i]  = r_u_neg[i] ? -$signed(r_u_mag[i][CoordW-1:0])
                                 : $signed(r_u_mag[i][CoordW-1:0]);
            w_w[i]  = r_w_neg[i] ? -$signed(r_w_mag[i][CoordW-1:0])
                                 : $signed(r_w_mag[i][CoordW-1:0]);
        end
        w_u_big   = |{r_u_mag[0][EdgeW-1:CoordW-1], r_u_mag[1][EdgeW-1:CoordW-1],
                      r_u_mag[2][EdgeW-1:CoordW-1]};
        w_w_big   = |{r_w_mag[0][EdgeW-1:CoordW-1], r_w_mag[1][EdgeW-1:CoordW-1],
                      r_w_mag[2][EdgeW-1:CoordW-1]};
        w_c_big   = |{r_c_mag[0][CrossW-1:NormFrac], r_c_mag[1][CrossW-1:NormFrac],
                      r_c_mag[2][CrossW-1:NormFrac]};
        w_c_small = ~|{r_c_mag[0][CrossW-1:NormFrac-1], r_c_mag[1][CrossW-1:NormFrac-1],
                       r_c_mag[2][CrossW-1:NormFrac-1]};
        w_c_zero  = ~|{r_c_mag[0], r_c_mag[1], r_c_mag[2]};

        w_acc_mag = w_acc[AccW-1] ? CrossW'(-w_acc) : CrossW'(w_acc);
        w_dot     = round_q30(w_acc);
        w_offs    = sat_coord(-{w_dot[DotW-1], w_dot});
        w_dist    = sat_coord({w_dot[DotW-1], w_dot} + (DotW + 1)'(r_pd[w_mrsp.tag]));

        w_div_idx  = (r_state == S_SQRT) ? 2'd0 : r_cnt[1:0] + 2'd1;
        w_divisor  = (r_state == S_SQRT) ? w_rres : r_len;
        w_dividend = {1'b0, r_c_mag[w_div_idx][NormFrac-1:0], {NormFrac{1'b0}}}
                   + DvdW'(w_divisor[RootW-1:1]);
        w_q        = $signed({1'b0, w_rres});
        w_rd_addr  = plane_pt(r_plane, r_cnt[1:0]);
    end

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire && t_op'(i_op) == OP_BUILD) begin
                    n_state = S_LOAD;
                end else if (w_fire && t_op'(i_op) == OP_TEST) begin
                    n_state = S_TEST;
                end
            end
            S_LOAD:   if (r_cnt == 3'd3) n_state = S_EDGE;
            S_EDGE:   n_state = S_FIT;
            S_FIT:    if (!w_u_big && !w_w_big) n_state = S_CROSS;
            S_CROSS:  if (w_mrsp.done && w_mrsp.tag == 3'd2) n_state = S_NORM;
            S_NORM: begin
                if (w_c_zero) begin
                    n_state = S_WRITE;
                end else if (!w_c_big && !w_c_small) begin
                    n_state = S_SUMSQ;
                end
            end
            S_SUMSQ:  if (w_mrsp.done) n_state = S_SQRT;
            S_SQRT:   if (w_rdone) n_state = S_DIV;
            S_DIV:    if (w_rdone && r_cnt == 3'd2) n_state = S_OFFS;
            S_OFFS:   if (w_mrsp.done) n_state = S_WRITE;
            S_WRITE:  n_state = (r_plane == 3'(NumPlanes - 1)) ? S_IDLE : S_LOAD;
            S_TEST:   if (w_mrsp.done && w_mrsp.tag == 3'(NumPlanes - 1)) n_state = S_RESULT;
            S_RESULT: if (!r_ovalid || i_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        w_mreq = '0;
        w_ma   = '0;
        w_mb   = '0;
        w_rcmd = '0;
        unique case (r_state)
            S_CROSS: begin
                w_mreq.valid = (r_cnt < 3'd6);
                w_mreq.clr   = !r_cnt[0];
                w_mreq.neg   = r_cnt[0];
                w_mreq.last  = r_cnt[0];
                w_mreq.tag   = {1'b0, r_cnt[2:1]};
                unique case (r_cnt)
                    3'd0:    begin w_ma = w_u[1]; w_mb = w_w[2]; end
                    3'd1:    begin w_ma = w_u[2]; w_mb = w_w[1]; end
                    3'd2:    begin w_ma = w_u[2]; w_mb = w_w[0]; end
                    3'd3:    begin w_ma = w_u[0]; w_mb = w_w[2]; end
                    3'd4:    begin w_ma = w_u[0]; w_mb = w_w[1]; end
                    default: begin w_ma = w_u[1]; w_mb = w_w[0]; end
                endcase
            end
            S_SUMSQ: begin
                w_mreq.valid = (r_cnt < 3'd3);
                w_mreq.clr   = (r_cnt == 3'd0);
                w_mreq.last  = (r_cnt == 3'd2);
                w_ma = $signed({1'b0, r_c_mag[r_cnt[1:0]][CoordW-2:0]});
                w_mb = w_ma;
                w_rcmd.start = w_mrsp.done;
            end
            S_SQRT: begin
                w_rcmd.start  = w_rdone;
                w_rcmd.is_div = 1'b1;
            end
            S_DIV: begin
                w_rcmd.start  = w_rdone && r_cnt != 3'd2;
                w_rcmd.is_div = 1'b1;
            end
            S_OFFS: begin
                w_mreq.valid = (r_cnt < 3'd3);
                w_mreq.clr   = (r_cnt == 3'd0);
                w_mreq.last  = (r_cnt == 3'd2);
                w_ma = r_n[r_cnt[1:0]];
                w_mb = r_p1[r_cnt[1:0]];
            end
            S_TEST: begin
                w_mreq.valid = (r_plane < 3'(NumPlanes));
                w_mreq.clr   = (r_cnt == 3'd0);
                w_mreq.last  = (r_cnt == 3'd2);
                w_mreq.tag   = r_plane;
                w_ma = r_pn[r_plane][r_cnt[1:0]];
                w_mb = r_ctr[r_cnt[1:0]];
            end
            default: ;
        endcase
    end

    fsc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_acc   (w_acc),
        .o_rsp   (w_mrsp)
    );

    fsc_rootdiv u_rootdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_rcmd),
        .i_radicand (w_acc[RadW-1:0]),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_rdone),
        .o_res      (w_rres)
    );

    // ---------------- corner memory ----------------
    always_ff @(posedge i_clk) begin
        if (w_fire && t_op'(i_op) == OP_LOAD) begin
            r_mem[i_corner_index] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_plane  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int p = 0; p < NumPlanes; p++) begin
                r_pd[p] <= '0;
                for (int a = 0; a < NumAxes; a++) begin
                    r_pn[p][a] <= '0;
                end
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    r_plane <= '0;
                    r_cnt   <= '0;
                end
                S_LOAD:  r_cnt <= (r_cnt == 3'd3) ? 3'd0 : r_cnt + 3'd1;
                S_EDGE:  r_cnt <= '0;
                S_FIT:   r_cnt <= '0;
                S_CROSS: if (r_cnt < 3'd6) r_cnt <= r_cnt + 3'd1;
                S_NORM:  r_cnt <= '0;
                S_SUMSQ: if (r_cnt < 3'd3) r_cnt <= r_cnt + 3'd1;
                S_SQRT:  r_cnt <= '0;
                S_DIV: begin
                    if (w_rdone) r_cnt <= (r_cnt == 3'd2) ? 3'd0 : r_cnt + 3'd1;
                end
                S_OFFS:  if (r_cnt < 3'd3) r_cnt <= r_cnt + 3'd1;
                S_WRITE: begin
                    r_cnt   <= '0;
                    r_plane <= r_plane + 3'd1;
                    for (int a = 0; a < NumAxes; a++) begin
                        r_pn[r_plane][a] <= r_zero ? '0 : r_n[a];
                    end
                    r_pd[r_plane] <= r_zero ? '0 : r_off;
                end
                S_TEST: begin
                    if (r_plane < 3'(NumPlanes)) begin
                        if (r_cnt == 3'd2) begin
                            r_cnt   <= '0;
                            r_plane <= r_plane + 3'd1;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                        end
                    end
                end
                S_RESULT: ;
                default: ;
            endcase
            if (r_state == S_RESULT && (!r_ovalid || i_ready)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_fire) begin
            r_ctr[0]  <= i_coord_x;
            r_ctr[1]  <= i_coord_y;
            r_ctr[2]  <= i_coord_z;
            r_rad     <= i_radius;
            r_outside <= 1'b0;
        end
        if (r_state == S_LOAD) begin
            for (int a = 0; a < NumAxes; a++) begin
                if (r_cnt == 3'd1) r_p1[a] <= r_rd[a*CoordW +: CoordW];
                if (r_cnt == 3'd2) r_p2[a] <= r_rd[a*CoordW +: CoordW];
                if (r_cnt == 3'd3) r_p3[a] <= r_rd[a*CoordW +: CoordW];
            end
        end
        if (r_state == S_EDGE) begin
            for (int a = 0; a < NumAxes; a++) begin
                r_u_neg[a] <= w_du[a][EdgeW-1];
                r_w_neg[a] <= w_dw[a][EdgeW-1];
                r_u_mag[a] <= w_du[a][EdgeW-1] ? EdgeW'(-w_du[a]) : EdgeW'(w_du[a]);
                r_w_mag[a] <= w_dw[a][EdgeW-1] ? EdgeW'(-w_dw[a]) : EdgeW'(w_dw[a]);
            end
        end
        // Each edge is scaled on its own until every magnitude fits in 31 bits.
        if (r_state == S_FIT) begin
            for (int a = 0; a < NumAxes; a++) begin
                if (w_u_big) r_u_mag[a] <= r_u_mag[a] >> 1;
                if (w_w_big) r_w_mag[a] <= r_w_mag[a] >> 1;
            end
        end
        if (r_state == S_CROSS && w_mrsp.done) begin
            r_c_neg[w_mrsp.tag[1:0]] <= w_acc[AccW-1];
            r_c_mag[w_mrsp.tag[1:0]] <= w_acc_mag;
        end
        // Bring the largest cross product magnitude into [2^29, 2^30).
        if (r_state == S_NORM) begin
            r_zero <= w_c_zero;
            for (int a = 0; a < NumAxes; a++) begin
                if (w_c_big) begin
                    r_c_mag[a] <= r_c_mag[a] >> 1;
                end else if (w_c_small && !w_c_zero) begin
                    r_c_mag[a] <= r_c_mag[a] << 1;
                end
            end
        end
        if (r_state == S_SQRT && w_rdone) begin
            r_len <= w_rres;
        end
        if (r_state == S_DIV && w_rdone) begin
            r_n[r_cnt[1:0]] <= r_c_neg[r_cnt[1:0]] ? -w_q : w_q;
        end
        if (r_state == S_OFFS && w_mrsp.done) begin
            r_off <= w_offs;
        end
        if (r_state == S_TEST && w_mrsp.done) begin
            if (w_dist > $signed({1'b0, r_rad})) r_outside <= 1'b1;
        end
        if (r_state == S_RESULT && (!r_ovalid || i_ready)) begin
            r_ores <= !r_outside;
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_inside_res = r_ores;

endmodule

[rtl/core/fsc_checker.sv]
// ----------------------------------------------------------------------------
// fsc_checker
// Port-level checks of the frustum sphere culler, bound to the top level.
// ----------------------------------------------------------------------------
module fsc_checker import fsc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [1:0] i_op,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_inside_res
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_inside_res))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // A result never appears in the cycle after an input transfer.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared without work");

    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_op == OP_BUILD |=> !o_ready ##1 !o_ready)
        else $error("build finished too early");

endmodule

bind frustum_sphere_culler fsc_checker u_fsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_op         (i_op),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_inside_res (o_inside_res)
);

[verif/tb_frustum_sphere_culler.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frustum_sphere_culler
// Self-checking testbench: loads frustum corners, builds planes and tests
// spheres, predicting every inside flag with a bit-exact fixed-point model.
// ----------------------------------------------------------------------------
module tb_frustum_sphere_culler;
    import fsc_pkg::*;

    class cull_scoreboard;
        longint corner_q16[24];
        int     normal_q30[18];
        longint offset_q16[6];
        bit     pending_inside[$];
        int     errors;

        function new();
            foreach (corner_q16[i]) corner_q16[i] = 0;
            foreach (normal_q30[i]) normal_q30[i] = 0;
            foreach (offset_q16[i]) offset_q16[i] = 0;
            errors = 0;
        endfunction

        function automatic longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function automatic longint magn(longint v);
            return (v < 0) ? -v : v;
        endfunction

        // Exact sum of Q2.30 products, shifted right by 30 with round half up.
        function automatic longint dot_round(int n0, int n1, int n2,
                                             longint p0, longint p1, longint p2);
            longint acc;
            acc = longint'(n0) * p0 + longint'(n1) * p1 + longint'(n2) * p2;
            return (acc + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function automatic void fit_edge(inout longint v0, inout longint v1,
                                         inout longint v2);
            longint m;
            int     s;
            m = magn(v0);
            if (magn(v1) > m) m = magn(v1);
            if (magn(v2) > m) m = magn(v2);
            s = 0;
            while ((m >> s) > 64'sd2147483647) s++;
            if (s > 0) begin
                v0 = (v0 < 0) ? -(magn(v0) >> s) : (v0 >> s);
                v1 = (v1 < 0) ? -(magn(v1) >> s) : (v1 >> s);
                v2 = (v2 < 0) ? -(magn(v2) >> s) : (v2 >> s);
            end
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic void build_one(int p);
            int              a, b, c, s;
            longint          u[3], w[3], cr[3], m;
            longint unsigned sum, len, q;
            a = plane_pt(3'(p), 2'd0);
            b = plane_pt(3'(p), 2'd1);
            c = plane_pt(3'(p), 2'd2);
            for (int i = 0; i < 3; i++) begin
                u[i] = corner_q16[3*a+i] - corner_q16[3*b+i];
                w[i] = corner_q16[3*a+i] - corner_q16[3*c+i];
            end
            fit_edge(u[0], u[1], u[2]);
            fit_edge(w[0], w[1], w[2]);
            cr[0] = u[1] * w[2] - u[2] * w[1];
            cr[1] = u[2] * w[0] - u[0] * w[2];
            cr[2] = u[0] * w[1] - u[1] * w[0];
            m = 0;
            for (int i = 0; i < 3; i++) if (magn(cr[i]) > m) m = magn(cr[i]);
            if (m == 0) begin
                for (int i = 0; i < 3; i++) normal_q30[3*p+i] = 0;
                offset_q16[p] = 0;
                return;
            end
            s = 0;
            if (m >= (64'sd1 <<< 30)) begin
                while ((m >> s) >= (64'sd1 <<< 30)) s++;
                for (int i = 0; i < 3; i++)
                    cr[i] = (cr[i] < 0) ? -(magn(cr[i]) >> s) : (cr[i] >> s);
            end else begin
                while ((m << s) < (64'sd1 <<< 29)) s++;
                for (int i = 0; i < 3; i++) cr[i] = cr[i] <<< s;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += magn(cr[i]) * magn(cr[i]);
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((longint'(magn(cr[i])) << 30) + (len >> 1)) / len;
                normal_q30[3*p+i] = (cr[i] < 0) ? -int'(q) : int'(q);
            end
            offset_q16[p] = sat32(-dot_round(normal_q30[3*p], normal_q30[3*p+1],
                normal_q30[3*p+2], corner_q16[3*a], corner_q16[3*a+1],
                corner_q16[3*a+2]));
        endfunction

        function automatic void note_input(logic [1:0] op, logic [2:0] idx,
                                           int x, int y, int z, logic [30:0] r);
            bit     in_flag;
            longint distance;
            case (t_op'(op))
                OP_LOAD: begin
                    corner_q16[3*idx]   = x;
                    corner_q16[3*idx+1] = y;
                    corner_q16[3*idx+2] = z;
                end
                OP_BUILD: begin
                    for (int p = 0; p < NumPlanes; p++) build_one(p);
                end
                OP_TEST: begin
                    in_flag = 1'b1;
                    for (int p = 0; p < NumPlanes; p++) begin
                        distance = sat32(dot_round(normal_q30[3*p], normal_q30[3*p+1],
                            normal_q30[3*p+2], x, y, z) + offset_q16[p]);
                        if (distance > longint'(r)) in_flag = 1'b0;
                    end
                    pending_inside.push_back(in_flag);
                end
                default: ;
            endcase
        endfunction

        function automatic void check_result(logic act);
            bit exp_v;
            if (pending_inside.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0b", $time, act);
                errors++;
                return;
            end
            exp_v = pending_inside.pop_front();
            if (act !== exp_v) begin
                $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                         $time, exp_v, act);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_op;
    logic [2:0]        i_corner_index;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic signed [31:0] i_coord_z;
    logic [30:0]       i_radius;
    logic              o_valid;
    logic              i_ready;
    logic              o_inside_res;

    cull_scoreboard sb = new();
    int  tx_idle_pct;
    int  rx_idle_pct;
    int  items_sent;
    int  quiet_cycles;
    int  frustum_far;

    frustum_sphere_culler DUT (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Output side: check each transfer and stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) sb.check_result(o_inside_res);
            i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // The quiet limit leaves ample margin for the longest item, a build.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 20000) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(t_op op, logic [2:0] idx, int x, int y, int z,
                             logic [30:0] r);
        bit done;
        i_op           <= op;
        i_corner_index <= idx;
        i_coord_x      <= x;
        i_coord_y      <= y;
        i_coord_z      <= z;
        i_radius       <= r;
        i_valid        <= 1'b1;
        done = 0;
        while (!done) begin
            @(posedge i_clk);
            if (i_valid && o_ready) done = 1;
        end
        sb.note_input(op, idx, x, y, z, r);
        items_sent++;
        if (items_sent < 650) begin
            tx_idle_pct = 27;
            rx_idle_pct = 75;
        end else if (items_sent < 1300) begin
            tx_idle_pct = 75;
            rx_idle_pct = 27;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic int units(int lo, int hi);
        return ($urandom_range(0, hi - lo) + lo) * 65536 + int'($urandom_range(0, 65535));
    endfunction

    // Corners 0..3 on the near rectangle, 4..7 on the far one, loaded in turn
    // from a random corner; sometimes the full 32-bit range for edge scaling.
    task automatic load_frustum(int kind);
        int a, b, n, base;
        int cx[8], cy[8], cz[8];
        a = units(1, 4);
        b = units(5, 30);
        n = units(1, 3);
        frustum_far = $urandom_range(10, 60);
        for (int k = 0; k < 8; k++) begin
            cx[k] = (((k % 4) == 1 || (k % 4) == 2) ? 1 : -1) * ((k < 4) ? a : b);
            cy[k] = (((k % 4) >= 2) ? 1 : -1) * ((k < 4) ? a : b);
            cz[k] = (k < 4) ? -n : -(frustum_far * 65536);
            if (kind == 1) begin
                cx[k] = int'($urandom);
                cy[k] = int'($urandom);
                cz[k] = int'($urandom);
            end else if (kind == 2) begin
                cx[k] = cx[0];
                cy[k] = (k % 2) ? cy[0] : cy[0] + 65536;
                cz[k] = cz[0];
            end
        end
        base = $urandom_range(0, 7);
        for (int k = 0; k < 8; k++)
            send_item(OP_LOAD, 3'((base + k) % 8), cx[(base + k) % 8],
                      cy[(base + k) % 8], cz[(base + k) % 8], 31'($urandom));
    endtask

    task automatic random_test();
        int lim;
        lim = frustum_far + 10;
        if ($urandom_range(0, 9) == 0) begin
            send_item(OP_TEST, 3'($urandom), int'($urandom), int'($urandom),
                      int'($urandom), 31'($urandom));
        end else begin
            send_item(OP_TEST, 3'($urandom), units(-lim, lim), units(-lim, lim),
                      units(-lim, 2), 31'($urandom_range(0, 8 * 65536)));
        end
    endtask

    initial begin
        int nt;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_op           = OP_NONE;
        i_corner_index = '0;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_coord_z      = '0;
        i_radius       = '0;
        items_sent     = 0;
        tx_idle_pct    = 27;
        rx_idle_pct    = 75;
        frustum_far    = 20;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Before any build every plane is zero, so spheres report inside.
        send_item(OP_TEST, 3'd0, 0, 0, 0, 31'd0);
        send_item(OP_TEST, 3'd7, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, '1);
        // Extreme corners force the edge scaling and saturated offsets.
        for (int k = 0; k < 8; k++)
            send_item(OP_LOAD, 3'(k), (k % 2) ? 32'sh7fffffff : 32'sh80000000,
                      (k % 4 >= 2) ? 32'sh7fffffff : 32'sh80000000,
                      (k >= 4) ? 32'sh7fffffff : 32'sh80000000, '1);
        send_item(OP_BUILD, 3'd0, 0, 0, 0, '0);
        send_item(OP_TEST, 3'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, '0);
        send_item(OP_TEST, 3'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '1);
        send_item(OP_NONE, 3'd5, 32'sh7fffffff, 0, 0, '1);
        // Coincident points give zero-length normals and zero planes.
        for (int k = 0; k < 8; k++)
            send_item(OP_LOAD, 3'(k), 65536, -65536, 131072, '0);
        send_item(OP_BUILD, 3'd0, 0, 0, 0, '0);
        send_item(OP_TEST, 3'd0, 32'sh7fffffff, 0, 0, '0);

        while (items_sent < 1950) begin
            nt = $urandom_range(0, 9);
            load_frustum((nt == 0) ? 1 : (nt == 1) ? 2 : 0);
            send_item(OP_BUILD, 3'($urandom), int'($urandom), int'($urandom),
                      int'($urandom), 31'($urandom));
            nt = $urandom_range(15, 60);
            for (int t = 0; t < nt; t++) begin
                if ($urandom_range(0, 29) == 0)
                    send_item(OP_NONE, 3'($urandom), int'($urandom), int'($urandom),
                              int'($urandom), 31'($urandom));
                else if ($urandom_range(0, 39) == 0)
                    send_item(OP_LOAD, 3'($urandom), units(-20, 20), units(-20, 20),
                              units(-40, 0), 31'($urandom));
                else
                    random_test();
            end
        end

        i_valid <= 1'b0;
        while (sb.pending_inside.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
